// ===== src/hmbs_pkg.sv =====
// ----------------------------------------------------------------------------
// hmbs_pkg
// Shared constants and controller/datapath interface types for the heightmap
// store and bilinear sampler.
// ----------------------------------------------------------------------------
package hmbs_pkg;

  // Store dimensions.
  localparam int MAX_TILES_X = 128;
  localparam int MAX_TILES_Z = 128;
  localparam int MAX_PLANES  = 4;
  localparam int DEPTH       = MAX_PLANES * MAX_TILES_Z * MAX_TILES_X;
  localparam int ADDR_W      = $clog2(DEPTH);

  // Field widths.
  localparam int OP_W       = 2;
  localparam int TILE_W     = 7;
  localparam int FRAC_W     = 7;
  localparam int PLANE_W    = 2;
  localparam int FOOT_W     = 7;
  localparam int HEIGHT_W   = 16;
  localparam int GRID_W     = 8;
  localparam int LEVEL_W    = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Coordinate compare width: holds a tile plus a footprint, and any grid size.
  localparam int MAX_TILES  = (MAX_TILES_X > MAX_TILES_Z) ? MAX_TILES_X : MAX_TILES_Z;
  localparam int COORD_SPAN = (MAX_TILES > 2 ** (TILE_W + 1)) ? MAX_TILES : 2 ** (TILE_W + 1);
  localparam int CMP_W      = $clog2(COORD_SPAN + 1);
  localparam int LVL_SPAN   = (MAX_PLANES > 2 ** LEVEL_W) ? MAX_PLANES : 2 ** LEVEL_W;
  localparam int LVL_CW     = $clog2(LVL_SPAN + 1);

  // Opcodes.
  localparam logic [OP_W-1:0] OP_WRITE     = 2'd0;
  localparam logic [OP_W-1:0] OP_FOOTPRINT = 2'd1;
  localparam logic [OP_W-1:0] OP_SAMPLE    = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE      = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_DEPTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_COUNT = 2'd2;

  // Step codes of the shared interpolation unit.
  localparam logic [1:0] STEP_ROW0 = 2'd0;
  localparam logic [1:0] STEP_ROW1 = 2'd1;
  localparam logic [1:0] STEP_COL  = 2'd2;

  typedef struct packed {
    logic       accept;     // latch the incoming word
    logic       prep;       // register the corner addresses
    logic       clr_en;     // clearing pass writes one entry
    logic       rd_en;      // read one corner
    logic [1:0] rd_idx;
    logic       calc_en;    // one step of the arithmetic unit
    logic [1:0] calc_step;
    logic       commit;     // load the result register; an in-range height write is stored
  } hmbs_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            err;
    logic            clr_last;
  } hmbs_sts_t;

endpackage

// ===== src/hmbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// hmbs_ctrl
// Sequencer: clearing pass after reset, input and output handshakes, corner
// read sequence and arithmetic steps.
// ----------------------------------------------------------------------------
module hmbs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  hmbs_pkg::hmbs_sts_t sts_i,
  output hmbs_pkg::hmbs_cmd_t cmd_o
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_PREP  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_CALC  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state_q, state_d;
  logic [1:0] rd_cnt_q, rd_cnt_d;
  logic [1:0] step_q, step_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  // The result register can take a new word when empty or emptied this cycle.
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d   = state_q;
    rd_cnt_d  = rd_cnt_q;
    step_d    = step_q;
    cmd_o     = '0;
    cmd_o.rd_idx    = rd_cnt_q;
    cmd_o.calc_step = step_q;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_PREP;
        end
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        rd_cnt_d   = 2'd0;
        if (sts_i.err || (sts_i.op inside {hmbs_pkg::OP_WRITE, hmbs_pkg::OP_NONE})) begin
          state_d = S_DONE;
        end else begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd_en = 1'b1;
        rd_cnt_d    = rd_cnt_q + 2'd1;
        if (rd_cnt_q == 2'd3) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        step_d  = hmbs_pkg::STEP_ROW0;
        state_d = S_CALC;
      end
      S_CALC: begin
        cmd_o.calc_en = 1'b1;
        if (sts_i.op == hmbs_pkg::OP_FOOTPRINT || step_q == hmbs_pkg::STEP_COL) begin
          state_d = S_DONE;
        end else begin
          step_d = step_q + 2'd1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      rd_cnt_q    <= 2'd0;
      step_q      <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_cnt_q    <= rd_cnt_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== src/hmbs_dp.sv =====
// ----------------------------------------------------------------------------
// hmbs_dp
// Datapath: configuration registers, bounds checks, corner address
// generation, height memory, shared interpolation unit and result register.
// ----------------------------------------------------------------------------
module hmbs_dp (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  hmbs_pkg::hmbs_cmd_t                    cmd_i,
  output hmbs_pkg::hmbs_sts_t                    sts_o,
  input  logic                                   cfg_we_i,
  input  logic        [hmbs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic        [hmbs_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic        [hmbs_pkg::OP_W-1:0]       opcode_i,
  input  logic        [hmbs_pkg::TILE_W-1:0]     tile_x_i,
  input  logic        [hmbs_pkg::TILE_W-1:0]     tile_z_i,
  input  logic        [hmbs_pkg::FRAC_W-1:0]     frac_x_i,
  input  logic        [hmbs_pkg::FRAC_W-1:0]     frac_z_i,
  input  logic        [hmbs_pkg::PLANE_W-1:0]    plane_i,
  input  logic        [hmbs_pkg::FOOT_W-1:0]     footprint_x_i,
  input  logic        [hmbs_pkg::FOOT_W-1:0]     footprint_z_i,
  input  logic signed [hmbs_pkg::HEIGHT_W-1:0]   write_height_i,
  output logic signed [hmbs_pkg::HEIGHT_W-1:0]   sw_height_o,
  output logic signed [hmbs_pkg::HEIGHT_W-1:0]   se_height_o,
  output logic signed [hmbs_pkg::HEIGHT_W-1:0]   ne_height_o,
  output logic signed [hmbs_pkg::HEIGHT_W-1:0]   nw_height_o,
  output logic signed [hmbs_pkg::HEIGHT_W-1:0]   center_height_o,
  output logic signed [hmbs_pkg::HEIGHT_W-1:0]   sampled_height_o,
  output logic                                   range_error_o
);

  localparam int CMP_W    = hmbs_pkg::CMP_W;
  localparam int ADDR_W   = hmbs_pkg::ADDR_W;
  localparam int HW       = hmbs_pkg::HEIGHT_W;
  localparam int FW       = hmbs_pkg::FRAC_W;
  localparam int SUM_W    = HW + FW + 3;
  localparam int CSUM_W   = HW + 2;
  localparam int FRAC_ONE = 2 ** FW;

  function automatic logic in_grid(input logic [CMP_W-1:0] x, input logic [CMP_W-1:0] z,
                                   input logic [CMP_W-1:0] ew, input logic [CMP_W-1:0] ed);
    return (x < ew) && (z < ed);
  endfunction

  function automatic logic [ADDR_W-1:0] tile_addr(input logic [CMP_W-1:0] x,
                                                  input logic [CMP_W-1:0] z,
                                                  input logic [hmbs_pkg::PLANE_W-1:0] p);
    logic [31:0] a;
    a = (32'(p) * 32'(hmbs_pkg::MAX_TILES_Z) + 32'(z)) * 32'(hmbs_pkg::MAX_TILES_X) + 32'(x);
    return a[ADDR_W-1:0];
  endfunction

  // Weighted sum of two heights with weights (1 - w) and w, floored to whole units.
  function automatic logic signed [HW-1:0] lerp(input logic signed [HW-1:0] a,
                                                input logic signed [HW-1:0] b,
                                                input logic [FW-1:0] w);
    logic [FW:0]              wa;
    logic [FW:0]              wb;
    logic signed [SUM_W-1:0]  s;
    logic signed [SUM_W-1:0]  sh;
    wa = (FW + 1)'(FRAC_ONE) - {1'b0, w};
    wb = {1'b0, w};
    s  = a * $signed({1'b0, wa}) + b * $signed({1'b0, wb});
    sh = s >>> FW;
    return sh[HW-1:0];
  endfunction

  // Configuration.
  logic [hmbs_pkg::GRID_W-1:0]  grid_width_q;
  logic [hmbs_pkg::GRID_W-1:0]  grid_depth_q;
  logic [hmbs_pkg::LEVEL_W-1:0] level_count_q;

  // Latched command word.
  logic [hmbs_pkg::OP_W-1:0]    op_q;
  logic [hmbs_pkg::TILE_W-1:0]  tx_q, tz_q;
  logic [FW-1:0]                lx_q, lz_q;
  logic [hmbs_pkg::PLANE_W-1:0] plane_q;
  logic [hmbs_pkg::FOOT_W-1:0]  fx_q, fz_q;
  logic signed [HW-1:0]         wh_q;

  logic [CMP_W-1:0]  eff_w, eff_d;
  logic [hmbs_pkg::LVL_CW-1:0] eff_l;
  logic [CMP_W-1:0]  tx_c, tz_c, fx_c, fz_c;
  logic [CMP_W-1:0]  x0, x1, z0, z1;
  logic              shift_x, shift_z, err;
  logic [CMP_W-1:0]  xs [4];
  logic [CMP_W-1:0]  zs [4];
  logic [ADDR_W-1:0] addr_d [4];
  logic [ADDR_W-1:0] addr_q [4];

  // Memory and its ports.
  logic [HW-1:0]     mem_q [hmbs_pkg::DEPTH];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [HW-1:0]     mem_wdata;
  logic [ADDR_W-1:0] clr_cnt_q;
  logic [HW-1:0]     rdata_q;
  logic              pend_q;
  logic [1:0]        pidx_q;

  logic signed [HW-1:0]     corner_q [4];
  logic signed [HW-1:0]     y0_q, y1_q, smp_q, center_q;
  logic signed [HW-1:0]     mul_a, mul_b, lerp_res;
  logic [FW-1:0]            mul_w;
  logic signed [CSUM_W-1:0] csum, csum_sh;

  logic fp_ok, smp_ok;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= hmbs_pkg::GRID_W'(128);
      grid_depth_q  <= hmbs_pkg::GRID_W'(128);
      level_count_q <= hmbs_pkg::LEVEL_W'(4);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        hmbs_pkg::REG_GRID_WIDTH:  grid_width_q  <= cfg_wdata_i;
        hmbs_pkg::REG_GRID_DEPTH:  grid_depth_q  <= cfg_wdata_i;
        hmbs_pkg::REG_LEVEL_COUNT: level_count_q <= cfg_wdata_i[hmbs_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q    <= opcode_i;
      tx_q    <= tile_x_i;
      tz_q    <= tile_z_i;
      lx_q    <= frac_x_i;
      lz_q    <= frac_z_i;
      plane_q <= plane_i;
      fx_q    <= footprint_x_i;
      fz_q    <= footprint_z_i;
      wh_q    <= write_height_i;
    end
  end

  // Bounds checks and corner coordinates.
  always_comb begin
    eff_w = (CMP_W'(grid_width_q) < CMP_W'(hmbs_pkg::MAX_TILES_X)) ?
            CMP_W'(grid_width_q) : CMP_W'(hmbs_pkg::MAX_TILES_X);
    eff_d = (CMP_W'(grid_depth_q) < CMP_W'(hmbs_pkg::MAX_TILES_Z)) ?
            CMP_W'(grid_depth_q) : CMP_W'(hmbs_pkg::MAX_TILES_Z);
    eff_l = (hmbs_pkg::LVL_CW'(level_count_q) < hmbs_pkg::LVL_CW'(hmbs_pkg::MAX_PLANES)) ?
            hmbs_pkg::LVL_CW'(level_count_q) : hmbs_pkg::LVL_CW'(hmbs_pkg::MAX_PLANES);
    tx_c  = CMP_W'(tx_q);
    tz_c  = CMP_W'(tz_q);
    fx_c  = CMP_W'(fx_q);
    fz_c  = CMP_W'(fz_q);
    err   = (op_q != hmbs_pkg::OP_NONE) &&
            (!in_grid(tx_c, tz_c, eff_w, eff_d) || (hmbs_pkg::LVL_CW'(plane_q) >= eff_l));
    // The footprint midpoint shift applies per axis only if the far edge is on the grid.
    shift_x = (op_q == hmbs_pkg::OP_FOOTPRINT) && in_grid(tx_c + fx_c, tz_c, eff_w, eff_d);
    shift_z = (op_q == hmbs_pkg::OP_FOOTPRINT) && in_grid(tx_c, tz_c + fz_c, eff_w, eff_d);
    x0 = shift_x ? tx_c + (fx_c >> 1) : tx_c;
    x1 = shift_x ? tx_c + ((fx_c + CMP_W'(1)) >> 1) : tx_c + CMP_W'(1);
    z0 = shift_z ? tz_c + (fz_c >> 1) : tz_c;
    z1 = shift_z ? tz_c + ((fz_c + CMP_W'(1)) >> 1) : tz_c + CMP_W'(1);
    // Corner order: south-west, south-east, north-east, north-west.
    xs[0] = x0; zs[0] = z0;
    xs[1] = x1; zs[1] = z0;
    xs[2] = x1; zs[2] = z1;
    xs[3] = x0; zs[3] = z1;
    // A corner off the grid reads the south-west entry instead.
    for (int k = 0; k < 4; k++) begin
      addr_d[k] = in_grid(xs[k], zs[k], eff_w, eff_d) ?
                  tile_addr(xs[k], zs[k], plane_q) : tile_addr(x0, z0, plane_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      for (int k = 0; k < 4; k++) begin
        addr_q[k] <= addr_d[k];
      end
    end
  end

  // Height memory: one write port shared with the clearing pass, one read port.
  assign mem_we    = cmd_i.clr_en || (cmd_i.commit && op_q == hmbs_pkg::OP_WRITE && !err);
  assign mem_waddr = cmd_i.clr_en ? clr_cnt_q : addr_q[0];
  assign mem_wdata = cmd_i.clr_en ? '0 : wh_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[addr_q[cmd_i.rd_idx]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
      pend_q    <= 1'b0;
    end else begin
      if (cmd_i.clr_en) begin
        clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
      end
      pend_q <= cmd_i.rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      pidx_q <= cmd_i.rd_idx;
    end
    if (pend_q) begin
      corner_q[pidx_q] <= rdata_q;
    end
  end

  // Shared interpolation unit: two rows along x, then one step along z; also the corner average.
  always_comb begin
    case (cmd_i.calc_step)
      hmbs_pkg::STEP_ROW0: begin
        mul_a = corner_q[0]; mul_b = corner_q[1]; mul_w = lx_q;
      end
      hmbs_pkg::STEP_ROW1: begin
        mul_a = corner_q[3]; mul_b = corner_q[2]; mul_w = lx_q;
      end
      hmbs_pkg::STEP_COL: begin
        mul_a = y0_q; mul_b = y1_q; mul_w = lz_q;
      end
      default: begin
        mul_a = '0; mul_b = '0; mul_w = '0;
      end
    endcase
    lerp_res = lerp(mul_a, mul_b, mul_w);
    csum     = CSUM_W'(corner_q[0]) + CSUM_W'(corner_q[1]) +
               CSUM_W'(corner_q[2]) + CSUM_W'(corner_q[3]);
    csum_sh  = csum >>> 2;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_en) begin
      case (cmd_i.calc_step)
        hmbs_pkg::STEP_ROW0: begin
          y0_q     <= lerp_res;
          center_q <= csum_sh[HW-1:0];
        end
        hmbs_pkg::STEP_ROW1: y1_q  <= lerp_res;
        hmbs_pkg::STEP_COL:  smp_q <= lerp_res;
        default: ;
      endcase
    end
  end

  // Result register; fields that do not belong to the opcode read as zero.
  assign fp_ok  = (op_q == hmbs_pkg::OP_FOOTPRINT) && !err;
  assign smp_ok = (op_q == hmbs_pkg::OP_SAMPLE) && !err;

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      sw_height_o      <= fp_ok ? corner_q[0] : '0;
      se_height_o      <= fp_ok ? corner_q[1] : '0;
      ne_height_o      <= fp_ok ? corner_q[2] : '0;
      nw_height_o      <= fp_ok ? corner_q[3] : '0;
      center_height_o  <= fp_ok ? center_q : '0;
      sampled_height_o <= smp_ok ? smp_q : '0;
      range_error_o    <= err;
    end
  end

  assign sts_o.op       = op_q;
  assign sts_o.err      = err;
  assign sts_o.clr_last = (clr_cnt_q == ADDR_W'(hmbs_pkg::DEPTH - 1));

endmodule

// ===== src/heightmap_store_bilinear_sampler_core.sv =====
// ----------------------------------------------------------------------------
// heightmap_store_bilinear_sampler_core
// Heightmap store with footprint corner reads and a bilinear sampler.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the whole height memory,
// one entry per cycle, and holds in_stall_o high until it is done;
// configuration writes are taken throughout. Each accepted word returns one
// result word, and no new word is taken before that result is committed. A
// height write, an out-of-range command or the unused opcode goes from
// address preparation straight to completion. A footprint read and a
// bilinear sample first read the four corners, one per cycle through the
// single read port of the height memory; a sample then takes three steps of
// the shared interpolation unit. A result that waits in the output register
// stalls only the completion of the following command.
module heightmap_store_bilinear_sampler_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic        [hmbs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic        [hmbs_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic        [hmbs_pkg::OP_W-1:0]       opcode_i,
  input  logic        [hmbs_pkg::TILE_W-1:0]     tile_x_i,
  input  logic        [hmbs_pkg::TILE_W-1:0]     tile_z_i,
  input  logic        [hmbs_pkg::FRAC_W-1:0]     frac_x_i,
  input  logic        [hmbs_pkg::FRAC_W-1:0]     frac_z_i,
  input  logic        [hmbs_pkg::PLANE_W-1:0]    plane_i,
  input  logic        [hmbs_pkg::FOOT_W-1:0]     footprint_x_i,
  input  logic        [hmbs_pkg::FOOT_W-1:0]     footprint_z_i,
  input  logic signed [hmbs_pkg::HEIGHT_W-1:0]   write_height_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [hmbs_pkg::HEIGHT_W-1:0]   sw_height_o,
  output logic signed [hmbs_pkg::HEIGHT_W-1:0]   se_height_o,
  output logic signed [hmbs_pkg::HEIGHT_W-1:0]   ne_height_o,
  output logic signed [hmbs_pkg::HEIGHT_W-1:0]   nw_height_o,
  output logic signed [hmbs_pkg::HEIGHT_W-1:0]   center_height_o,
  output logic signed [hmbs_pkg::HEIGHT_W-1:0]   sampled_height_o,
  output logic                                   range_error_o
);

  hmbs_pkg::hmbs_cmd_t cmd;
  hmbs_pkg::hmbs_sts_t sts;

  hmbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  hmbs_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .opcode_i         (opcode_i),
    .tile_x_i         (tile_x_i),
    .tile_z_i         (tile_z_i),
    .frac_x_i         (frac_x_i),
    .frac_z_i         (frac_z_i),
    .plane_i          (plane_i),
    .footprint_x_i    (footprint_x_i),
    .footprint_z_i    (footprint_z_i),
    .write_height_i   (write_height_i),
    .sw_height_o      (sw_height_o),
    .se_height_o      (se_height_o),
    .ne_height_o      (ne_height_o),
    .nw_height_o      (nw_height_o),
    .center_height_o  (center_height_o),
    .sampled_height_o (sampled_height_o),
    .range_error_o    (range_error_o)
  );

endmodule

// ===== test/height_query_checker.sv =====
// ----------------------------------------------------------------------------
// height_query_checker
// Watches the command, result and register ports of the heightmap core. It
// keeps a shadow height memory and its own copy of the grid sizes, works out
// the reply to every accepted command word, and compares each returned word
// with the oldest pending reply, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module height_query_checker
  import hmbs_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic        [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic        [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  input  logic                         in_stall_o,
  input  logic        [OP_W-1:0]       opcode_i,
  input  logic        [TILE_W-1:0]     tile_x_i,
  input  logic        [TILE_W-1:0]     tile_z_i,
  input  logic        [FRAC_W-1:0]     frac_x_i,
  input  logic        [FRAC_W-1:0]     frac_z_i,
  input  logic        [PLANE_W-1:0]    plane_i,
  input  logic        [FOOT_W-1:0]     footprint_x_i,
  input  logic        [FOOT_W-1:0]     footprint_z_i,
  input  logic signed [HEIGHT_W-1:0]   write_height_i,
  input  logic                         out_valid_o,
  input  logic                         out_stall_i,
  input  logic signed [HEIGHT_W-1:0]   sw_height_o,
  input  logic signed [HEIGHT_W-1:0]   se_height_o,
  input  logic signed [HEIGHT_W-1:0]   ne_height_o,
  input  logic signed [HEIGHT_W-1:0]   nw_height_o,
  input  logic signed [HEIGHT_W-1:0]   center_height_o,
  input  logic signed [HEIGHT_W-1:0]   sampled_height_o,
  input  logic                         range_error_o,
  output int                           fail_count_o,
  output int                           pending_o
);

  typedef struct packed {
    logic signed [HEIGHT_W-1:0] sw;
    logic signed [HEIGHT_W-1:0] se;
    logic signed [HEIGHT_W-1:0] ne;
    logic signed [HEIGHT_W-1:0] nw;
    logic signed [HEIGHT_W-1:0] center;
    logic signed [HEIGHT_W-1:0] sampled;
    logic                       range_error;
  } height_reply_t;

  logic signed [HEIGHT_W-1:0] shadow_heights [0:DEPTH-1];
  logic        [GRID_W-1:0]   width_reg;
  logic        [GRID_W-1:0]   depth_reg;
  logic        [LEVEL_W-1:0]  levels_reg;

  height_reply_t expected_replies [$];
  height_reply_t want;
  height_reply_t got;
  int            fault_total;

  function automatic int span_x();
    return (width_reg < MAX_TILES_X) ? int'(width_reg) : MAX_TILES_X;
  endfunction

  function automatic int span_z();
    return (depth_reg < MAX_TILES_Z) ? int'(depth_reg) : MAX_TILES_Z;
  endfunction

  function automatic int span_planes();
    return (levels_reg < MAX_PLANES) ? int'(levels_reg) : MAX_PLANES;
  endfunction

  function automatic bit on_grid(int x, int z);
    return x >= 0 && x < span_x() && z >= 0 && z < span_z();
  endfunction

  function automatic int height_at(int x, int z, int p);
    return int'(shadow_heights[(p * MAX_TILES_Z + z) * MAX_TILES_X + x]);
  endfunction

  // Works out the reply to one command and applies a height write.
  function automatic height_reply_t resolve_command(
    logic [OP_W-1:0] op, int tx, int tz, int lx, int lz, int p, int fx, int fz,
    logic signed [HEIGHT_W-1:0] wh);
    height_reply_t r;
    int x0, x1, z0, z1;
    int sw, se, ne, nw;
    int a, b, c, d, y0, y1;
    r = '0;
    if (op != OP_NONE && (!on_grid(tx, tz) || p >= span_planes())) begin
      r.range_error = 1'b1;
    end else if (op == OP_WRITE) begin
      shadow_heights[(p * MAX_TILES_Z + tz) * MAX_TILES_X + tx] = wh;
    end else if (op == OP_FOOTPRINT) begin
      x0 = tx;
      x1 = tx + 1;
      z0 = tz;
      z1 = tz + 1;
      // The midpoint shift applies per axis only when the far edge is on the grid.
      if (on_grid(tx + fx, tz)) begin
        x0 = tx + (fx >> 1);
        x1 = tx + ((fx + 1) >> 1);
      end
      if (on_grid(tx, tz + fz)) begin
        z0 = tz + (fz >> 1);
        z1 = tz + ((fz + 1) >> 1);
      end
      sw = height_at(x0, z0, p);
      se = on_grid(x1, z0) ? height_at(x1, z0, p) : sw;
      ne = on_grid(x1, z1) ? height_at(x1, z1, p) : sw;
      nw = on_grid(x0, z1) ? height_at(x0, z1, p) : sw;
      r.sw = HEIGHT_W'(sw);
      r.se = HEIGHT_W'(se);
      r.ne = HEIGHT_W'(ne);
      r.nw = HEIGHT_W'(nw);
      r.center = HEIGHT_W'((sw + se + ne + nw) >>> 2);
    end else if (op == OP_SAMPLE) begin
      a = height_at(tx, tz, p);
      b = on_grid(tx + 1, tz) ? height_at(tx + 1, tz, p) : a;
      d = on_grid(tx, tz + 1) ? height_at(tx, tz + 1, p) : a;
      c = on_grid(tx + 1, tz + 1) ? height_at(tx + 1, tz + 1, p) : a;
      y0 = (a * (128 - lx) + b * lx) >>> 7;
      y1 = (d * (128 - lx) + c * lx) >>> 7;
      r.sampled = HEIGHT_W'((y0 * (128 - lz) + y1 * lz) >>> 7);
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) shadow_heights[i] = '0;
      width_reg  = 8'd128;
      depth_reg  = 8'd128;
      levels_reg = 3'd4;
      expected_replies.delete();
      fault_total = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_GRID_WIDTH:  width_reg  = cfg_wdata_i;
          REG_GRID_DEPTH:  depth_reg  = cfg_wdata_i;
          REG_LEVEL_COUNT: levels_reg = cfg_wdata_i[LEVEL_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        expected_replies.push_back(resolve_command(opcode_i, int'(tile_x_i),
          int'(tile_z_i), int'(frac_x_i), int'(frac_z_i), int'(plane_i),
          int'(footprint_x_i), int'(footprint_z_i), write_height_i));
      end
      if (out_valid_o && !out_stall_i) begin
        got = '{sw_height_o, se_height_o, ne_height_o, nw_height_o, center_height_o,
                sampled_height_o, range_error_o};
        if (expected_replies.size() == 0) begin
          fault_total++;
          if (fault_total <= 10)
            $display("%0t: result word with none pending: sw=%0d se=%0d ne=%0d nw=%0d",
                     $realtime, got.sw, got.se, got.ne, got.nw,
                     "  c=%0d s=%0d e=%0b", got.center, got.sampled, got.range_error);
        end else begin
          want = expected_replies.pop_front();
          if (got.sw !== want.sw || got.se !== want.se || got.ne !== want.ne ||
              got.nw !== want.nw || got.center !== want.center ||
              got.sampled !== want.sampled || got.range_error !== want.range_error) begin
            fault_total++;
            if (fault_total <= 10) begin
              $display("%0t: result mismatch", $realtime);
              $display("  expected sw=%0d se=%0d ne=%0d nw=%0d c=%0d s=%0d e=%0b",
                       want.sw, want.se, want.ne, want.nw, want.center, want.sampled,
                       want.range_error);
              $display("  actual   sw=%0d se=%0d ne=%0d nw=%0d c=%0d s=%0d e=%0b",
                       got.sw, got.se, got.ne, got.nw, got.center, got.sampled,
                       got.range_error);
            end
          end
        end
      end
      pending_o    <= expected_replies.size();
      fail_count_o <= fault_total;
    end
  end

endmodule

// ===== test/heightmap_store_bilinear_sampler_core_tb.sv =====
// ----------------------------------------------------------------------------
// heightmap_store_bilinear_sampler_core_tb
// Drives height writes, footprint corner reads and bilinear samples into the
// heightmap core across several grid sizes, with random gaps on both sides.
// The checker beside the core predicts and compares every result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module heightmap_store_bilinear_sampler_core_tb;
  import hmbs_pkg::*;

  // No word is accepted while the clearing pass after reset runs.
  localparam int QUIET_LIMIT = 300000;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic        [CFG_IDX_W-1:0]  cfg_index_i;
  logic        [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                         in_valid_i;
  logic                         in_stall_o;
  logic        [OP_W-1:0]       opcode_i;
  logic        [TILE_W-1:0]     tile_x_i;
  logic        [TILE_W-1:0]     tile_z_i;
  logic        [FRAC_W-1:0]     frac_x_i;
  logic        [FRAC_W-1:0]     frac_z_i;
  logic        [PLANE_W-1:0]    plane_i;
  logic        [FOOT_W-1:0]     footprint_x_i;
  logic        [FOOT_W-1:0]     footprint_z_i;
  logic signed [HEIGHT_W-1:0]   write_height_i;
  logic                         out_valid_o;
  logic                         out_stall_i;
  logic signed [HEIGHT_W-1:0]   sw_height_o;
  logic signed [HEIGHT_W-1:0]   se_height_o;
  logic signed [HEIGHT_W-1:0]   ne_height_o;
  logic signed [HEIGHT_W-1:0]   nw_height_o;
  logic signed [HEIGHT_W-1:0]   center_height_o;
  logic signed [HEIGHT_W-1:0]   sampled_height_o;
  logic                         range_error_o;

  int   fail_count;
  int   pending;
  int   quiet_cycles;
  logic calm;
  int   x_span;
  int   z_span;
  int   plane_span;

  heightmap_store_bilinear_sampler_core dut (.*);

  height_query_checker u_checker (
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .*
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 23);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic send_word(logic [OP_W-1:0] op, logic [TILE_W-1:0] tx, logic [TILE_W-1:0] tz,
                           logic [FRAC_W-1:0] lx, logic [FRAC_W-1:0] lz,
                           logic [PLANE_W-1:0] p, logic [FOOT_W-1:0] fx,
                           logic [FOOT_W-1:0] fz, logic signed [HEIGHT_W-1:0] wh);
    if (!calm && $urandom_range(99) < 23) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 50);
    end
    in_valid_i     <= 1'b1;
    opcode_i       <= op;
    tile_x_i       <= tx;
    tile_z_i       <= tz;
    frac_x_i       <= lx;
    frac_z_i       <= lz;
    plane_i        <= p;
    footprint_x_i  <= fx;
    footprint_z_i  <= fz;
    write_height_i <= wh;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Unused fields of the directed words carry random values.
  task automatic put_height(int x, int z, int p, logic signed [HEIGHT_W-1:0] h);
    send_word(OP_WRITE, TILE_W'(x), TILE_W'(z), FRAC_W'($urandom), FRAC_W'($urandom),
              PLANE_W'(p), FOOT_W'($urandom), FOOT_W'($urandom), h);
  endtask

  task automatic get_corners(int x, int z, int p, int fx, int fz);
    send_word(OP_FOOTPRINT, TILE_W'(x), TILE_W'(z), FRAC_W'($urandom), FRAC_W'($urandom),
              PLANE_W'(p), FOOT_W'(fx), FOOT_W'(fz), HEIGHT_W'($urandom));
  endtask

  task automatic get_sample(int x, int z, int p, int lx, int lz);
    send_word(OP_SAMPLE, TILE_W'(x), TILE_W'(z), FRAC_W'(lx), FRAC_W'(lz),
              PLANE_W'(p), FOOT_W'($urandom), FOOT_W'($urandom), HEIGHT_W'($urandom));
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic set_grid(int w, int d, int l);
    write_reg(REG_GRID_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_GRID_DEPTH, CFG_DATA_W'(d));
    write_reg(REG_LEVEL_COUNT, CFG_DATA_W'(l));
    x_span     = (w < MAX_TILES_X) ? w : MAX_TILES_X;
    z_span     = (d < MAX_TILES_Z) ? d : MAX_TILES_Z;
    plane_span = (l < MAX_PLANES) ? l : MAX_PLANES;
  endtask

  // Lets every pending result come back before registers change again.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (16) @(posedge clk_i);
  endtask

  // Mostly near the low corner and the far edge, where heights get written,
  // now and then one past the edge or anywhere at all.
  function automatic logic [TILE_W-1:0] pick_tile(int span);
    int r;
    int lim;
    r   = $urandom_range(99);
    lim = (span > 8) ? 8 : span;
    if (span == 0 || r >= 88) return TILE_W'($urandom_range(127));
    if (r < 55) return TILE_W'($urandom_range(lim - 1));
    if (r < 78) return TILE_W'(span - 1 - int'($urandom_range(lim - 1)));
    return TILE_W'((span > 127) ? 127 : span);
  endfunction

  task automatic run_random(int count, int calm_count);
    int r;
    logic [OP_W-1:0]            op;
    logic [PLANE_W-1:0]         p;
    logic [FOOT_W-1:0]          fx, fz;
    logic [FRAC_W-1:0]          lx, lz;
    logic signed [HEIGHT_W-1:0] h;
    for (int i = 0; i < count; i++) begin
      calm <= (i < calm_count);
      r = $urandom_range(99);
      if (r < 35) op = OP_WRITE;
      else if (r < 65) op = OP_FOOTPRINT;
      else if (r < 95) op = OP_SAMPLE;
      else op = OP_NONE;
      if (plane_span == 0 || $urandom_range(99) < 15) p = PLANE_W'($urandom_range(3));
      else p = PLANE_W'($urandom_range(plane_span - 1));
      r = $urandom_range(99);
      fx = (r < 40) ? 7'd1 : (r < 70) ? 7'($urandom_range(4)) : 7'($urandom_range(127));
      r = $urandom_range(99);
      fz = (r < 40) ? 7'd1 : (r < 70) ? 7'($urandom_range(4)) : 7'($urandom_range(127));
      r = $urandom_range(99);
      lx = (r < 10) ? 7'd0 : (r < 20) ? 7'd127 : 7'($urandom_range(127));
      r = $urandom_range(99);
      lz = (r < 10) ? 7'd0 : (r < 20) ? 7'd127 : 7'($urandom_range(127));
      r = $urandom_range(99);
      h = (r < 8) ? 16'sh7FFF : (r < 16) ? 16'sh8000 : 16'($urandom_range(65535));
      send_word(op, pick_tile(x_span), pick_tile(z_span), lx, lz, p, fx, fz, h);
    end
    calm <= 1'b0;
  endtask

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = REG_GRID_WIDTH;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    opcode_i       = OP_NONE;
    tile_x_i       = '0;
    tile_z_i       = '0;
    frac_x_i       = '0;
    frac_z_i       = '0;
    plane_i        = '0;
    footprint_x_i  = '0;
    footprint_z_i  = '0;
    write_height_i = '0;
    out_stall_i    = 1'b0;
    calm           = 1'b0;
    x_span         = MAX_TILES_X;
    z_span         = MAX_TILES_Z;
    plane_span     = MAX_PLANES;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Extreme heights around the origin, then corners and samples over them.
    put_height(0, 0, 0, 16'sh7FFF);
    put_height(1, 0, 0, 16'sh8000);
    put_height(1, 1, 0, 16'sh7FFF);
    put_height(0, 1, 0, 16'sh8000);
    get_corners(0, 0, 0, 1, 1);
    get_corners(0, 0, 0, 0, 0);
    get_sample(0, 0, 0, 0, 0);
    get_sample(0, 0, 0, 127, 127);
    get_sample(0, 0, 0, 64, 0);
    // At the far corner the missing neighbors fall back to the south-west height.
    put_height(127, 127, 3, 16'sh5555);
    put_height(126, 127, 3, 16'shAAAA);
    get_corners(127, 127, 3, 1, 1);
    get_corners(126, 127, 3, 1, 1);
    get_sample(127, 127, 3, 127, 127);
    get_sample(126, 126, 3, 100, 27);
    // Large footprints: one fitting and two running off the grid along x.
    get_corners(0, 0, 0, 127, 127);
    get_corners(100, 0, 0, 127, 127);
    get_corners(64, 64, 1, 64, 63);
    send_word(OP_NONE, 7'd127, 7'd127, 7'd127, 7'd127, 2'd3, 7'd127, 7'd127, 16'shFFFF);
    put_height(5, 5, 2, 16'sh7FFF);
    get_sample(5, 5, 2, 127, 0);
    drain();

    run_random(180, 130);
    drain();
    set_grid(255, 255, 7);
    run_random(60, 0);
    drain();
    set_grid(1, 1, 1);
    run_random(60, 0);
    drain();
    set_grid(5, 3, 2);
    run_random(170, 0);
    drain();
    // With a size of zero nothing is on the grid.
    set_grid(0, 10, 2);
    run_random(25, 0);
    drain();
    set_grid(10, 0, 0);
    run_random(25, 0);
    drain();
    set_grid(17, 9, 3);
    run_random(160, 0);
    drain();
    set_grid(2, 128, 4);
    run_random(80, 0);
    drain();
    set_grid(128, 128, 4);
    run_random(60, 0);
    drain();

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
